// ===== design/streaming_top_k_selector_assert.svh =====
// Assertion macros used by the checker file of the top-K selector.
`ifndef STREAMING_TOP_K_SELECTOR_ASSERT_SVH
`define STREAMING_TOP_K_SELECTOR_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define TKSEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("top-k selector check failed");

// Consequent must hold in the same cycle as the antecedent.
`define TKSEL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("top-k selector check failed");

`endif

// ===== design/tksel_pkg.sv =====
// Shared types and constants of the top-K selector.
package tksel_pkg;

	localparam int SCORE_W = 32;

	typedef logic signed [SCORE_W-1:0] score_t;

	// Score reported for a rank that no score occupies.
	localparam score_t MOST_NEG = {1'b1, {(SCORE_W-1){1'b0}}};

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

endpackage

// ===== design/tksel_front.sv =====
// Front stage: accept score words and tag them with their position in the vector.
module tksel_front import tksel_pkg::*; #(
	parameter int MAX_CLASSES = 1024,
	parameter int POS_W       = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  score_t           score_value,
	input  logic             vector_end,
	input  logic             q_full,
	output logic             full,
	output logic             wr_en,
	output score_t           wr_score,
	output logic [POS_W-1:0] wr_pos,
	output logic             wr_last
);

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CLASSES - 1);

	logic [POS_W-1:0] pos_q;

	assign full     = q_full;
	assign wr_en    = push && !q_full;
	assign wr_score = score_value;
	assign wr_pos   = pos_q;
	assign wr_last  = vector_end;

	// Restart at zero after the last word; otherwise count up and hold at the top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (wr_en) begin
			if (vector_end) begin
				pos_q <= '0;
			end else if (pos_q != POS_MAX) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

// ===== design/tksel_queue.sv =====
// Short queue between the front and the back of the top-K selector.
module tksel_queue import tksel_pkg::*; #(
	parameter int WORD_W = 43
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [WORD_W-1:0] wr_word,
	input  logic              rd_en,
	output logic              rd_valid,
	output logic [WORD_W-1:0] rd_word,
	output logic              q_full
);

	logic [WORD_W-1:0] mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign rd_valid = (cnt_q != '0);
	assign q_full   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign rd_word  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/tksel_back.sv =====
// Back stage: compare-insert each score into the sorted row of kept slots.
module tksel_back import tksel_pkg::*; #(
	parameter int TOP_K = 5,
	parameter int POS_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_valid,
	input  score_t           rd_score,
	input  logic [POS_W-1:0] rd_pos,
	input  logic             rd_last,
	input  logic             can_load,
	output logic             rd_en,
	output logic             load,
	output score_t           load_score [TOP_K],
	output logic [POS_W-1:0] load_pos   [TOP_K],
	output logic             load_used  [TOP_K]
);

	score_t           score_q [TOP_K];
	logic [POS_W-1:0] pos_q   [TOP_K];
	logic [TOP_K-1:0] used_q;

	// gt[j]: the incoming score belongs at or above slot j.
	logic [TOP_K-1:0] gt;
	score_t           nxt_score [TOP_K];
	logic [POS_W-1:0] nxt_pos   [TOP_K];
	logic [TOP_K-1:0] nxt_used;

	// Hold a last word until the result buffer can take the finished row.
	assign rd_en = rd_valid && (!rd_last || can_load);
	assign load  = rd_en && rd_last;

	genvar j;
	generate
		for (j = 0; j < TOP_K; j++) begin : g_slot
			assign gt[j] = !used_q[j] || (rd_score > score_q[j]);

			if (j == 0) begin : g_head
				always_comb begin
					if (gt[0]) begin
						nxt_score[0] = rd_score;
						nxt_pos[0]   = rd_pos;
						nxt_used[0]  = 1'b1;
					end else begin
						nxt_score[0] = score_q[0];
						nxt_pos[0]   = pos_q[0];
						nxt_used[0]  = used_q[0];
					end
				end
			end else begin : g_tail
				// Take the new score at the first hit, shift down below it.
				always_comb begin
					if (gt[j-1]) begin
						nxt_score[j] = score_q[j-1];
						nxt_pos[j]   = pos_q[j-1];
						nxt_used[j]  = used_q[j-1];
					end else if (gt[j]) begin
						nxt_score[j] = rd_score;
						nxt_pos[j]   = rd_pos;
						nxt_used[j]  = 1'b1;
					end else begin
						nxt_score[j] = score_q[j];
						nxt_pos[j]   = pos_q[j];
						nxt_used[j]  = used_q[j];
					end
				end
			end

			assign load_score[j] = nxt_score[j];
			assign load_pos[j]   = nxt_pos[j];
			assign load_used[j]  = nxt_used[j];

			always_ff @(posedge clk) begin
				if (rd_en) begin
					score_q[j] <= nxt_score[j];
					pos_q[j]   <= nxt_pos[j];
				end
			end
		end
	endgenerate

	// Drop every slot after the last word of a vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (rd_en) begin
			used_q <= rd_last ? '0 : nxt_used;
		end
	end

endmodule

// ===== design/tksel_drain.sv =====
// Result buffer: hold a finished row and hand it out one rank per word.
module tksel_drain import tksel_pkg::*; #(
	parameter int TOP_K  = 5,
	parameter int POS_W  = 10,
	parameter int RANK_W = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  score_t            load_score [TOP_K],
	input  logic [POS_W-1:0]  load_pos   [TOP_K],
	input  logic              load_used  [TOP_K],
	input  logic              pop,
	output logic              can_load,
	output logic              empty,
	output logic [RANK_W-1:0] rank,
	output logic [POS_W-1:0]  class_position,
	output score_t            kept_score,
	output logic              slot_filled,
	output logic              run_last
);

	localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(TOP_K - 1);

	score_t            sc_q [TOP_K];
	logic [POS_W-1:0]  ps_q [TOP_K];
	logic [TOP_K-1:0]  us_q;
	logic [RANK_W-1:0] rank_q;
	logic              busy_q;
	logic              take;
	logic              at_last;

	assign take     = pop && busy_q;
	assign at_last  = (rank_q == RANK_LAST);
	assign can_load = !busy_q || (take && at_last);

	assign empty          = !busy_q;
	assign rank           = rank_q;
	assign slot_filled    = us_q[0];
	assign kept_score     = us_q[0] ? sc_q[0] : MOST_NEG;
	assign class_position = us_q[0] ? ps_q[0] : '0;
	assign run_last       = at_last;

	genvar i;
	generate
		for (i = 0; i < TOP_K; i++) begin : g_ent
			if (i < TOP_K - 1) begin : g_mid
				always_ff @(posedge clk) begin
					if (load) begin
						sc_q[i] <= load_score[i];
						ps_q[i] <= load_pos[i];
					end else if (take) begin
						sc_q[i] <= sc_q[i+1];
						ps_q[i] <= ps_q[i+1];
					end
				end
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						us_q[i] <= 1'b0;
					end else if (load) begin
						us_q[i] <= load_used[i];
					end else if (take) begin
						us_q[i] <= us_q[i+1];
					end
				end
			end else begin : g_end
				always_ff @(posedge clk) begin
					if (load) begin
						sc_q[i] <= load_score[i];
						ps_q[i] <= load_pos[i];
					end
				end
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						us_q[i] <= 1'b0;
					end else if (load) begin
						us_q[i] <= load_used[i];
					end
				end
			end
		end
	endgenerate

	// Advance one rank per word taken; a new row restarts at rank zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rank_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			rank_q <= '0;
		end else if (take) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end
			rank_q <= rank_q + 1'b1;
		end
	end

endmodule

// ===== design/streaming_top_k_selector.sv =====
// Streaming top-K selector: one score per cycle in unless full, K ranked words out per vector.
// A vector's rank-0 word reaches the result ports through the queue and the result buffer.
// Throughput: one score per cycle unless full; TOP_K words per vector, one per cycle while popped.
// A last score waits in the queue only while the previous vector's words are still unread.
// Reset (arst_n low) empties the queue and the result buffer, clears every kept slot
// and the position counter; the block is ready in the first cycle after release.
module streaming_top_k_selector import tksel_pkg::*; #(
	parameter int TOP_K       = 5,
	parameter int MAX_CLASSES = 1024,
	localparam int RANK_W     = (TOP_K > 1) ? $clog2(TOP_K) : 1,
	localparam int POS_W      = $clog2(MAX_CLASSES)
) (
	input  logic              clk,
	input  logic              arst_n,
	// Score side
	input  logic              push,
	output logic              full,
	input  score_t            score_value,
	input  logic              vector_end,
	// Result side
	output logic              empty,
	input  logic              pop,
	output logic [RANK_W-1:0] rank,
	output logic [POS_W-1:0]  class_position,
	output score_t            kept_score,
	output logic              slot_filled,
	output logic              run_last
);

	// Queue word layout: {last, position, score}.
	localparam int WORD_W = 1 + POS_W + SCORE_W;

	logic              wr_en;
	score_t            wr_score;
	logic [POS_W-1:0]  wr_pos;
	logic              wr_last;
	logic              q_full;
	logic              rd_valid;
	logic              rd_en;
	logic [WORD_W-1:0] rd_word;
	logic              can_load;
	logic              load;
	score_t            load_score [TOP_K];
	logic [POS_W-1:0]  load_pos   [TOP_K];
	logic              load_used  [TOP_K];

	// Front: accept a word and tag it with its class position.
	tksel_front #(
		.MAX_CLASSES (MAX_CLASSES),
		.POS_W       (POS_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.score_value (score_value),
		.vector_end  (vector_end),
		.q_full      (q_full),
		.full        (full),
		.wr_en       (wr_en),
		.wr_score    (wr_score),
		.wr_pos      (wr_pos),
		.wr_last     (wr_last)
	);

	// Queue: lets the front keep accepting while the back waits on the result buffer.
	tksel_queue #(
		.WORD_W (WORD_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_word  ({wr_last, wr_pos, wr_score}),
		.rd_en    (rd_en),
		.rd_valid (rd_valid),
		.rd_word  (rd_word),
		.q_full   (q_full)
	);

	// Back: parallel compare against all kept slots, insert, shift the rest down.
	// Ties keep the earlier class because only a strictly greater score enters.
	tksel_back #(
		.TOP_K (TOP_K),
		.POS_W (POS_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_valid   (rd_valid),
		.rd_score   (rd_word[SCORE_W-1:0]),
		.rd_pos     (rd_word[SCORE_W +: POS_W]),
		.rd_last    (rd_word[WORD_W-1]),
		.can_load   (can_load),
		.rd_en      (rd_en),
		.load       (load),
		.load_score (load_score),
		.load_pos   (load_pos),
		.load_used  (load_used)
	);

	// Result buffer: holds the finished row so the back can start the next vector.
	tksel_drain #(
		.TOP_K  (TOP_K),
		.POS_W  (POS_W),
		.RANK_W (RANK_W)
	) u_drain (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (load),
		.load_score     (load_score),
		.load_pos       (load_pos),
		.load_used      (load_used),
		.pop            (pop),
		.can_load       (can_load),
		.empty          (empty),
		.rank           (rank),
		.class_position (class_position),
		.kept_score     (kept_score),
		.slot_filled    (slot_filled),
		.run_last       (run_last)
	);

endmodule

// ===== design/tksel_checker.sv =====
// Port-level checks of the top-K selector and their binding to the top level.
`include "streaming_top_k_selector_assert.svh"

module tksel_checker import tksel_pkg::*; #(
	parameter int TOP_K       = 5,
	parameter int MAX_CLASSES = 1024,
	localparam int RANK_W     = (TOP_K > 1) ? $clog2(TOP_K) : 1,
	localparam int POS_W      = $clog2(MAX_CLASSES)
) (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input logic [RANK_W-1:0] rank,
	input logic [POS_W-1:0]  class_position,
	input score_t            kept_score,
	input logic              slot_filled,
	input logic              run_last
);

	// A word that is not taken stays put.
	`TKSEL_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(rank) && $stable(kept_score))

	// Within a run the ranks follow one after another with no gap.
	`TKSEL_ASSERT_NEXT(a_rank_step, clk, arst_n, pop && !empty && !run_last, !empty && (rank == $past(rank) + 1'b1))

	// Empty ranks lie below all filled ones.
	`TKSEL_ASSERT_NEXT(a_empty_below, clk, arst_n, pop && !empty && !run_last && !slot_filled, !slot_filled)

	// Filled ranks come out in non-increasing score order.
	`TKSEL_ASSERT_NEXT(a_descending, clk, arst_n, pop && !empty && !run_last && slot_filled, !slot_filled || (kept_score <= $past(kept_score)))

	// An empty rank reports the most negative score at position zero.
	`TKSEL_ASSERT_SAME(a_empty_value, clk, arst_n, !empty && !slot_filled, (kept_score == MOST_NEG) && (class_position == '0))

endmodule

bind streaming_top_k_selector tksel_checker #(
	.TOP_K       (TOP_K),
	.MAX_CLASSES (MAX_CLASSES)
) u_tksel_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.rank           (rank),
	.class_position (class_position),
	.kept_score     (kept_score),
	.slot_filled    (slot_filled),
	.run_last       (run_last)
);

// ===== tb/streaming_top_k_selector_tb.sv =====
// Self-checking bench for the streaming top-K selector: predicts each vector's ranked words.
module streaming_top_k_selector_tb;
	import tksel_pkg::*;

	localparam int TOP_K        = 5;
	localparam int MAX_CLASSES  = 1024;
	localparam int RANK_W       = (TOP_K > 1) ? $clog2(TOP_K) : 1;
	localparam int POS_W        = $clog2(MAX_CLASSES);
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_ITEMS = 100;
	// Long enough to run the position counter into saturation.
	localparam int LONG_VECTOR  = MAX_CLASSES + 6;

	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [POS_W-1:0]  pos_t;

	// One ranked word as the block should present it.
	typedef struct {
		rank_t  rank;
		pos_t   pos;
		score_t score;
		logic   filled;
		logic   last;
	} ranked_word_t;

	// Receiver behavior, held for a random stretch of cycles.
	typedef enum int {
		POP_ALWAYS,
		POP_MOSTLY,
		POP_RARELY,
		POP_HELD
	} pop_mode_t;

	// Tracks the top-K slots of the open vector and the ranked words still owed.
	class rank_tracker;
		score_t       kept[TOP_K];
		pos_t         where[TOP_K];
		bit           used[TOP_K];
		pos_t         next_pos;
		ranked_word_t due[$];
		int           errors;

		function new();
			clear();
			errors = 0;
		endfunction

		function void clear();
			for (int i = 0; i < TOP_K; i++) begin
				kept[i]  = MOST_NEG;
				where[i] = '0;
				used[i]  = 1'b0;
			end
			next_pos = '0;
		endfunction

		// Insert below any equal score; an empty slot takes anything.
		function void place_score(score_t s);
			int p;
			p = TOP_K;
			for (int j = 0; j < TOP_K; j++)
				if (p == TOP_K && (!used[j] || s > kept[j]))
					p = j;
			if (p == TOP_K)
				return;
			for (int j = TOP_K - 1; j > p; j--) begin
				kept[j]  = kept[j-1];
				where[j] = where[j-1];
				used[j]  = used[j-1];
			end
			kept[p]  = s;
			where[p] = next_pos;
			used[p]  = 1'b1;
		endfunction

		function void take_score(score_t s, logic last);
			ranked_word_t w;
			place_score(s);
			if (next_pos < pos_t'(MAX_CLASSES - 1))
				next_pos++;
			if (!last)
				return;
			for (int r = 0; r < TOP_K; r++) begin
				w.rank   = rank_t'(r);
				w.pos    = used[r] ? where[r] : '0;
				w.score  = used[r] ? kept[r] : MOST_NEG;
				w.filled = used[r];
				w.last   = (r == TOP_K - 1);
				due.push_back(w);
			end
			clear();
		endfunction

		task report(string what);
			$display("MISMATCH: %s", what);
			errors++;
		endtask

		task check_word(rank_t rk, pos_t ps, score_t sc, logic fl, logic ls);
			ranked_word_t w;
			if (due.size() == 0) begin
				report($sformatf("word at rank %0d with no vector closed", rk));
				return;
			end
			w = due.pop_front();
			if (rk !== w.rank)
				report($sformatf("rank %0d, want %0d", rk, w.rank));
			if (ps !== w.pos)
				report($sformatf("rank %0d class_position %0d, want %0d", w.rank, ps, w.pos));
			if (sc !== w.score)
				report($sformatf("rank %0d kept_score %0d, want %0d", w.rank, sc, w.score));
			if (fl !== w.filled)
				report($sformatf("rank %0d slot_filled %b, want %b", w.rank, fl, w.filled));
			if (ls !== w.last)
				report($sformatf("rank %0d run_last %b, want %b", w.rank, ls, w.last));
		endtask

		task flush_check();
			if (due.size() != 0)
				report($sformatf("%0d ranked words never arrived", due.size()));
		endtask
	endclass

	logic   clk         = 1'b0;
	logic   arst_n      = 1'b0;
	logic   push        = 1'b0;
	logic   pop         = 1'b0;
	score_t score_value = '0;
	logic   vector_end  = 1'b0;

	logic   full;
	logic   empty;
	rank_t  rank;
	pos_t   class_position;
	score_t kept_score;
	logic   slot_filled;
	logic   run_last;

	rank_tracker ranks_due = new();
	int          burst_left = 0;
	int          items_sent = 0;

	streaming_top_k_selector #(
		.TOP_K       (TOP_K),
		.MAX_CLASSES (MAX_CLASSES)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.score_value    (score_value),
		.vector_end     (vector_end),
		.empty          (empty),
		.pop            (pop),
		.rank           (rank),
		.class_position (class_position),
		.kept_score     (kept_score),
		.slot_filled    (slot_filled),
		.run_last       (run_last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Sample both handshakes on the edge itself: the values read here are the
	// ones that held just before it, since every driver updates with NBAs.
	// Check the outgoing word first so a fresh vector can never satisfy it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				ranks_due.check_word(rank, class_position, kept_score, slot_filled, run_last);
			if (push && !full)
				ranks_due.take_score(score_value, vector_end);
		end
	end

	// Present one score word and hold it until the block takes it. Between
	// bursts, drop push for a random gap; bursts are mostly short, sometimes
	// long enough to stream with no idling at all.
	task automatic send_score(score_t s, logic last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(1, 10);
		end
		burst_left--;
		push        <= 1'b1;
		score_value <= s;
		vector_end  <= last;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	// Mix raw 32-bit values, the two extremes and a narrow band that forces ties.
	function automatic score_t pick_score();
		case ($urandom_range(0, 9))
			0:       return MOST_NEG;
			1:       return score_t'(32'h7FFF_FFFF);
			2, 3, 4: return score_t'($urandom_range(0, 6)) - 3;
			default: return score_t'($urandom);
		endcase
	endfunction

	task automatic send_vector(int len);
		for (int i = 0; i < len; i++)
			send_score(pick_score(), i == len - 1);
	endtask

	// Receiver: pick a pop behavior, hold it for a stretch, then pick again.
	// Full stalls stay short so the score side backs up without starving.
	initial begin
		pop_mode_t mode;
		int        stretch;
		wait (arst_n === 1'b1);
		forever begin
			mode    = pop_mode_t'($urandom_range(0, 3));
			stretch = (mode == POP_HELD) ? $urandom_range(4, 24) : $urandom_range(8, 48);
			repeat (stretch) begin
				@(posedge clk);
				case (mode)
					POP_ALWAYS: pop <= 1'b1;
					POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
					POP_RARELY: pop <= ($urandom_range(0, 3) == 0);
					default:    pop <= 1'b0;
				endcase
			end
		end
	end

	// Watchdog: fail the run if it has not finished by the cycle limit.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		int     target;
		score_t s;

		// Hold reset, then release it on an edge.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// A lone last score: it fills rank 0 even at the most negative value,
		// and the four ranks below come out empty.
		send_score(MOST_NEG, 1'b1);

		// Ties: equal scores keep the earlier class, a later equal one is refused.
		send_score(score_t'(7), 1'b0);
		send_score(score_t'(7), 1'b0);
		send_score(score_t'(3), 1'b0);
		send_score(score_t'(7), 1'b0);
		send_score(score_t'(7), 1'b0);
		send_score(score_t'(7), 1'b0);
		send_score(score_t'(7), 1'b1);

		// Extremes of the score range; the maximum wins and the last score is ranked second.
		send_score(score_t'(0), 1'b0);
		send_score(score_t'(-1), 1'b0);
		send_score(score_t'(32'h7FFF_FFFF), 1'b0);
		send_score(score_t'(1), 1'b0);
		send_score(MOST_NEG, 1'b0);
		send_score(score_t'(32'h7FFF_FFFE), 1'b1);

		// Short vector: two empty ranks at the bottom.
		send_score(score_t'(10), 1'b0);
		send_score(score_t'(20), 1'b0);
		send_score(score_t'(30), 1'b1);

		// Rising scores: each one displaces the whole list downward.
		for (int i = 1; i <= 6; i++)
			send_score(score_t'(i), i == 6);

		// Random vectors, mostly short, a few longer than K.
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target)
			send_vector(($urandom_range(0, 3) == 0) ? $urandom_range(6, 16)
			                                        : $urandom_range(1, 8));

		// One vector past MAX_CLASSES: the tail scores top the list, and the ranked
		// ones all share the saturated position.
		for (int i = 0; i < LONG_VECTOR; i++) begin
			if (i >= LONG_VECTOR - 10)
				s = score_t'(1000 + i);
			else
				s = -score_t'($urandom_range(1, 1048576));
			send_score(s, i == LONG_VECTOR - 1);
		end

		// A few random vectors to show the state cleared after the long one.
		send_vector(3);
		send_vector(7);

		// Drain: wait for every owed word, then keep watching for strays before the final check.
		push <= 1'b0;
		while (ranks_due.due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		ranks_due.flush_check();

		if (ranks_due.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
